### rtl/core/lqb_pkg.sv
package lqb_pkg;

    // width of a component fed to the normalizer (covers end - start plus slack)
    localparam int VW = 36;
    // width of a length out of the normalizer (32-bit root shifted by up to 5)
    localparam int LW = 37;
    // width of the pre-root shift
    localparam int SW = 3;
    // largest pre-root shift
    localparam int S_MAX = 5;

    localparam logic [1:0] COL_WIDTH  = 2'd0;
    localparam logic [1:0] COL_LENGTH = 2'd1;
    localparam logic [1:0] COL_NORMAL = 2'd2;
    localparam logic [1:0] COL_ORIGIN = 2'd3;

    typedef logic signed [VW-1:0] t_nval;

    typedef struct packed {
        logic               shown;
        logic [3:0][2:0][31:0] vec;
    } t_packet;

    // round to nearest, ties away from zero, dropping f fraction bits
    function automatic logic signed [63:0] f_round(input logic signed [63:0] p, input int f);
        logic [63:0] mag;
        logic [63:0] r;
        mag = p[63] ? 64'(-p) : 64'(p);
        r   = (mag + (64'd1 << (f - 1))) >> f;
        return p[63] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

### rtl/core/line_quad_basis.sv
// channel  direction  handshake                  payload
// in       to block   i_in_valid / o_in_stall    start, end, line_width (one line per word)
// out      from block o_out_valid / i_out_stall  shown, column, vec_x/y/z, last
//
// a line passes through three normalizers in a row, each a 32-stage root and a FRAC_BITS+2
// stage divider, before its first word appears.
// a visible line leaves as four words, a hidden one as one word;
// the output word sequencer sets the rate and stalls the whole pipeline while it works.
// reset is synchronous, active low, and clears only the valid bits and the output column index.
// i_out_stall on a held word freezes the pipeline at once; nothing is lost or repeated.
module line_quad_basis #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic [30:0]        i_line_width,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_shown,
    output logic [1:0]         o_column,
    output logic signed [31:0] o_vec_x,
    output logic signed [31:0] o_vec_y,
    output logic signed [31:0] o_vec_z,
    output logic               o_last
);

    localparam int F        = FRAC_BITS;
    localparam int UW       = F + 3;
    localparam int VW       = lqb_pkg::VW;
    localparam int LW       = lqb_pkg::LW;
    localparam int EPS_Q    = ((1 << F) + 5000) / 10000;
    localparam int NEAR_Y_Q = ((99 << F) + 50) / 100;
    localparam int PW1      = 96 + 99 + 31;
    localparam int PW2      = 3 * UW + LW + 1 + 96 + 31;
    localparam int PW3      = 6 * UW + LW + 1 + 96 + 31;

    logic en;

    // input register and difference
    logic               r0_v;
    logic signed [31:0] r0_st [3];
    logic signed [31:0] r0_end [3];
    logic [30:0]        r0_w;

    logic               r1_v;
    logic signed [31:0] r1_st [3];
    logic signed [32:0] r1_d [3];
    logic [30:0]        r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_in_valid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_st  <= '{i_start_x, i_start_y, i_start_z};
            r0_end <= '{i_end_x, i_end_y, i_end_z};
            r0_w   <= i_line_width;
            for (int i = 0; i < 3; i++) begin
                r1_d[i] <= 33'(r0_end[i]) - 33'(r0_st[i]);
            end
            r1_st <= r0_st;
            r1_w  <= r0_w;
        end
    end

    // direction
    lqb_pkg::t_nval     n1_in [3];
    logic               n1_v;
    logic signed [UW-1:0] n1_u [3];
    logic [LW-1:0]      n1_len;
    logic [PW1-1:0]     n1_pay;
    logic signed [31:0] n1_st [3];
    logic signed [32:0] n1_d [3];
    logic [30:0]        n1_w;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_in[i] = VW'(r1_d[i]);
        end
    end

    lqb_norm #(
        .F (F),
        .UW(UW),
        .PW(PW1)
    ) u_norm_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_v     (n1_in),
        .i_pay   ({r1_st[2], r1_st[1], r1_st[0], r1_d[2], r1_d[1], r1_d[0], r1_w}),
        .o_valid (n1_v),
        .o_u     (n1_u),
        .o_len   (n1_len),
        .o_pay   (n1_pay)
    );

    assign {n1_st[2], n1_st[1], n1_st[0], n1_d[2], n1_d[1], n1_d[0], n1_w} = n1_pay;

    // short test, cross axis pick, midpoint
    logic [UW-1:0]      ay;
    logic               near_y;
    lqb_pkg::t_nval     xc [3];
    logic signed [32:0] half [3];
    logic signed [33:0] mid [3];

    always_comb begin
        ay     = n1_u[1][UW-1] ? UW'(-n1_u[1]) : UW'(n1_u[1]);
        near_y = (ay >= UW'(NEAR_Y_Q));
        if (!near_y) begin
            xc[0] = -VW'(n1_u[2]);
            xc[1] = '0;
            xc[2] = VW'(n1_u[0]);
        end else begin
            xc[0] = '0;
            xc[1] = VW'(n1_u[2]);
            xc[2] = -VW'(n1_u[1]);
        end
        for (int i = 0; i < 3; i++) begin
            // halve toward zero
            half[i] = (n1_d[i] + $signed({32'd0, n1_d[i][32]})) >>> 1;
            mid[i]  = 34'(n1_st[i]) + 34'(half[i]);
        end
    end

    logic                 r5_v;
    logic signed [UW-1:0] r5_y [3];
    logic [LW-1:0]        r5_len;
    logic                 r5_short;
    logic [31:0]          r5_mid [3];
    logic [30:0]          r5_w;
    lqb_pkg::t_nval       r5_xc [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= n1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_y     <= n1_u;
            r5_len   <= n1_len;
            r5_short <= (n1_len < LW'(EPS_Q)) || (n1_len == '0);
            for (int i = 0; i < 3; i++) begin
                r5_mid[i] <= mid[i][31:0];
            end
            r5_w  <= n1_w;
            r5_xc <= xc;
        end
    end

    // width axis
    logic                 n2_v;
    logic signed [UW-1:0] n2_u [3];
    logic [PW2-1:0]       n2_pay;
    logic signed [UW-1:0] n2_y [3];
    logic [LW-1:0]        n2_len;
    logic                 n2_short;
    logic [31:0]          n2_mid [3];
    logic [30:0]          n2_w;

    lqb_norm #(
        .F (F),
        .UW(UW),
        .PW(PW2)
    ) u_norm_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r5_v),
        .i_v     (r5_xc),
        .i_pay   ({r5_y[2], r5_y[1], r5_y[0], r5_len, r5_short,
                   r5_mid[2], r5_mid[1], r5_mid[0], r5_w}),
        .o_valid (n2_v),
        .o_u     (n2_u),
        .o_len   (),
        .o_pay   (n2_pay)
    );

    assign {n2_y[2], n2_y[1], n2_y[0], n2_len, n2_short,
            n2_mid[2], n2_mid[1], n2_mid[0], n2_w} = n2_pay;

    // normal: products, then round and subtract
    logic                   r6_v;
    logic signed [2*UW-1:0] r6_p [6];
    logic signed [UW-1:0]   r6_xa [3];
    logic signed [UW-1:0]   r6_y [3];
    logic [LW-1:0]          r6_len;
    logic                   r6_short;
    logic [31:0]            r6_mid [3];
    logic [30:0]            r6_w;

    logic                   r7_v;
    lqb_pkg::t_nval         r7_zc [3];
    logic signed [UW-1:0]   r7_xa [3];
    logic signed [UW-1:0]   r7_y [3];
    logic [LW-1:0]          r7_len;
    logic                   r7_short;
    logic [31:0]            r7_mid [3];
    logic [30:0]            r7_w;

    logic signed [63:0]     pr [6];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pr[i] = lqb_pkg::f_round(64'(r6_p[i]), F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r6_v <= n2_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_p[0]  <= n2_u[1] * n2_y[2];
            r6_p[1]  <= n2_u[2] * n2_y[1];
            r6_p[2]  <= n2_u[2] * n2_y[0];
            r6_p[3]  <= n2_u[0] * n2_y[2];
            r6_p[4]  <= n2_u[0] * n2_y[1];
            r6_p[5]  <= n2_u[1] * n2_y[0];
            r6_xa    <= n2_u;
            r6_y     <= n2_y;
            r6_len   <= n2_len;
            r6_short <= n2_short;
            r6_mid   <= n2_mid;
            r6_w     <= n2_w;
            for (int i = 0; i < 3; i++) begin
                r7_zc[i] <= VW'(pr[2*i] - pr[2*i+1]);
            end
            r7_xa    <= r6_xa;
            r7_y     <= r6_y;
            r7_len   <= r6_len;
            r7_short <= r6_short;
            r7_mid   <= r6_mid;
            r7_w     <= r6_w;
        end
    end

    logic                 n3_v;
    logic signed [UW-1:0] n3_u [3];
    logic [PW3-1:0]       n3_pay;
    logic signed [UW-1:0] n3_xa [3];
    logic signed [UW-1:0] n3_y [3];
    logic [LW-1:0]        n3_len;
    logic                 n3_short;
    logic [31:0]          n3_mid [3];
    logic [30:0]          n3_w;

    lqb_norm #(
        .F (F),
        .UW(UW),
        .PW(PW3)
    ) u_norm_normal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_v     (r7_zc),
        .i_pay   ({r7_xa[2], r7_xa[1], r7_xa[0], r7_y[2], r7_y[1], r7_y[0], r7_len,
                   r7_short, r7_mid[2], r7_mid[1], r7_mid[0], r7_w}),
        .o_valid (n3_v),
        .o_u     (n3_u),
        .o_len   (),
        .o_pay   (n3_pay)
    );

    assign {n3_xa[2], n3_xa[1], n3_xa[0], n3_y[2], n3_y[1], n3_y[0], n3_len,
            n3_short, n3_mid[2], n3_mid[1], n3_mid[0], n3_w} = n3_pay;

    // scaled columns
    logic                     r8_v;
    logic signed [UW+31:0]    r8_pw [3];
    logic signed [UW+LW:0]    r8_pl [3];
    logic signed [UW-1:0]     r8_za [3];
    logic [31:0]              r8_mid [3];
    logic                     r8_short;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v <= n3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r8_pw[i] <= n3_xa[i] * $signed({1'b0, n3_w});
                r8_pl[i] <= n3_y[i] * $signed({1'b0, n3_len});
            end
            r8_za    <= n3_u;
            r8_mid   <= n3_mid;
            r8_short <= n3_short;
        end
    end

    lqb_pkg::t_packet pkt;

    always_comb begin
        pkt.shown = !r8_short;
        for (int i = 0; i < 3; i++) begin
            pkt.vec[lqb_pkg::COL_WIDTH][i]  =
                lqb_pkg::f_sat32(lqb_pkg::f_round(64'(r8_pw[i]), F));
            pkt.vec[lqb_pkg::COL_LENGTH][i] =
                lqb_pkg::f_sat32(lqb_pkg::f_round(64'(r8_pl[i]), F));
            pkt.vec[lqb_pkg::COL_NORMAL][i] = lqb_pkg::f_sat32(64'(r8_za[i]));
            pkt.vec[lqb_pkg::COL_ORIGIN][i] = r8_mid[i];
        end
    end

    lqb_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r8_v),
        .i_pkt    (pkt),
        .o_take   (en),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_shown  (o_shown),
        .o_column (o_column),
        .o_vec_x  (o_vec_x),
        .o_vec_y  (o_vec_y),
        .o_vec_z  (o_vec_z),
        .o_last   (o_last)
    );

    assign o_in_stall = !en;

    // the pipeline only halts behind a word that is waiting or being spelled out
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no output word pending");

    a_hidden_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_shown) |-> (o_last && o_column == lqb_pkg::COL_WIDTH))
        else $error("hidden line not a single final word");

    a_column_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=>
        (o_out_valid && o_shown && o_column == $past(o_column) + 2'd1))
        else $error("column sequence broken");

endmodule

### rtl/core/lqb_isqrt.sv
module lqb_isqrt #(
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_rad,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [31:0]   o_root,
    output logic [PW-1:0] o_pay
);

    logic          r_v   [32];
    logic [63:0]   r_rem [32];
    logic [63:0]   r_r   [32];
    logic [PW-1:0] r_pay [32];

    // one result bit per stage, trial bit walks down two places each step
    for (genvar k = 0; k < 32; k++) begin : g_st
        logic          v_in;
        logic [63:0]   rem_in;
        logic [63:0]   r_in;
        logic [PW-1:0] p_in;
        logic [63:0]   bitv;
        logic [64:0]   trial;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_rad;
            assign r_in   = '0;
            assign p_in   = i_pay;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign r_in   = r_r[k-1];
            assign p_in   = r_pay[k-1];
        end

        assign bitv  = 64'd1 << (62 - 2 * k);
        assign trial = {1'b0, r_in} + {1'b0, bitv};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, rem_in} >= trial) begin
                    r_rem[k] <= rem_in - trial[63:0];
                    r_r[k]   <= (r_in >> 1) + bitv;
                end else begin
                    r_rem[k] <= rem_in;
                    r_r[k]   <= r_in >> 1;
                end
                r_pay[k] <= p_in;
            end
        end
    end

    assign o_valid = r_v[31];
    assign o_root  = r_r[31][31:0];
    assign o_pay   = r_pay[31];

endmodule

### rtl/core/lqb_udiv.sv
module lqb_udiv #(
    parameter int QW = 18,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [63:0]   i_num [3],
    input  logic [63:0]   i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [QW-1:0] o_q [3],
    output logic [63:0]   o_den,
    output logic [PW-1:0] o_pay
);

    logic          r_v   [QW];
    logic [63:0]   r_rem [QW][3];
    logic [QW-1:0] r_q   [QW][3];
    logic [63:0]   r_den [QW];
    logic [PW-1:0] r_pay [QW];

    // restoring division, three lanes sharing one divisor, msb first
    for (genvar j = 0; j < QW; j++) begin : g_st
        logic          v_in;
        logic [63:0]   rem_in [3];
        logic [QW-1:0] q_in   [3];
        logic [63:0]   den_in;
        logic [PW-1:0] p_in;
        logic [63:0]   trial;

        if (j == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_num;
            assign q_in   = '{default: '0};
            assign den_in = i_den;
            assign p_in   = i_pay;
        end else begin : g_next
            assign v_in   = r_v[j-1];
            assign rem_in = r_rem[j-1];
            assign q_in   = r_q[j-1];
            assign den_in = r_den[j-1];
            assign p_in   = r_pay[j-1];
        end

        assign trial = den_in << (QW - 1 - j);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= trial) begin
                        r_rem[j][i] <= rem_in[i] - trial;
                        r_q[j][i]   <= q_in[i] | (QW'(1) << (QW - 1 - j));
                    end else begin
                        r_rem[j][i] <= rem_in[i];
                        r_q[j][i]   <= q_in[i];
                    end
                end
                r_den[j] <= den_in;
                r_pay[j] <= p_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_den   = r_den[QW-1];
    assign o_pay   = r_pay[QW-1];

endmodule

### rtl/core/lqb_norm.sv
module lqb_norm #(
    parameter int F  = 16,
    parameter int UW = 19,
    parameter int PW = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  lqb_pkg::t_nval          i_v [3],
    input  logic [PW-1:0]           i_pay,
    output logic                    o_valid,
    output logic signed [UW-1:0]    o_u [3],
    output logic [lqb_pkg::LW-1:0]  o_len,
    output logic [PW-1:0]           o_pay
);

    localparam int VW  = lqb_pkg::VW;
    localparam int LW  = lqb_pkg::LW;
    localparam int SW  = lqb_pkg::SW;
    localparam int QW  = UW - 1;
    localparam int QPW = 3 * VW + 3 + SW + PW;
    localparam int DPW = 1 + 3 + PW;

    // magnitudes and the shift that keeps each below 2^31
    logic [VW-1:0] mag [3];
    logic [2:0]    sgn;
    logic [VW-1:0] mx;
    logic [SW-1:0] s_sel;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sgn[i] = i_v[i][VW-1];
            mag[i] = sgn[i] ? VW'(-i_v[i]) : VW'(i_v[i]);
        end
        mx = mag[0];
        if (mag[1] > mx) begin
            mx = mag[1];
        end
        if (mag[2] > mx) begin
            mx = mag[2];
        end
        s_sel = SW'(lqb_pkg::S_MAX);
        for (int s = lqb_pkg::S_MAX; s >= 0; s--) begin
            if ((mx >> s) < (VW'(1) << 31)) begin
                s_sel = SW'(s);
            end
        end
    end

    logic          r1_v;
    logic [VW-1:0] r1_m [3];
    logic [2:0]    r1_sgn;
    logic [SW-1:0] r1_s;
    logic [PW-1:0] r1_pay;

    logic          r2_v;
    logic [61:0]   r2_sq [3];
    logic [VW-1:0] r2_m [3];
    logic [2:0]    r2_sgn;
    logic [SW-1:0] r2_s;
    logic [PW-1:0] r2_pay;

    logic          r3_v;
    logic [63:0]   r3_sum;
    logic [VW-1:0] r3_m [3];
    logic [2:0]    r3_sgn;
    logic [SW-1:0] r3_s;
    logic [PW-1:0] r3_pay;

    logic [30:0]   t_sh [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_sh[i] = 31'(r1_m[i] >> r1_s);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m   <= mag;
            r1_sgn <= sgn;
            r1_s   <= s_sel;
            r1_pay <= i_pay;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i] <= t_sh[i] * t_sh[i];
            end
            r2_m   <= r1_m;
            r2_sgn <= r1_sgn;
            r2_s   <= r1_s;
            r2_pay <= r1_pay;
            r3_sum <= 64'(r2_sq[0]) + 64'(r2_sq[1]) + 64'(r2_sq[2]);
            r3_m   <= r2_m;
            r3_sgn <= r2_sgn;
            r3_s   <= r2_s;
            r3_pay <= r2_pay;
        end
    end

    logic           q_v;
    logic [31:0]    q_root;
    logic [QPW-1:0] q_pay;
    logic [VW-1:0]  q_m [3];
    logic [2:0]     q_sgn;
    logic [SW-1:0]  q_s;
    logic [PW-1:0]  q_ext;

    lqb_isqrt #(
        .PW(QPW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r3_v),
        .i_rad   (r3_sum),
        .i_pay   ({r3_m[2], r3_m[1], r3_m[0], r3_sgn, r3_s, r3_pay}),
        .o_valid (q_v),
        .o_root  (q_root),
        .o_pay   (q_pay)
    );

    assign {q_m[2], q_m[1], q_m[0], q_sgn, q_s, q_ext} = q_pay;

    logic [LW-1:0] den;
    assign den = LW'(q_root) << q_s;

    logic          r4_v;
    logic [63:0]   r4_num [3];
    logic [63:0]   r4_den;
    logic          r4_zero;
    logic [2:0]    r4_sgn;
    logic [PW-1:0] r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= q_v;
        end
    end

    // numerator carries half the divisor so the quotient rounds
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r4_num[i] <= (64'(q_m[i]) << F) + 64'(den >> 1);
            end
            r4_den  <= 64'(den);
            r4_zero <= (q_root == '0);
            r4_sgn  <= q_sgn;
            r4_pay  <= q_ext;
        end
    end

    logic           d_v;
    logic [QW-1:0]  d_q [3];
    logic [63:0]    d_den;
    logic [DPW-1:0] d_pay;
    logic           d_zero;
    logic [2:0]     d_sgn;
    logic [PW-1:0]  d_ext;

    lqb_udiv #(
        .QW(QW),
        .PW(DPW)
    ) u_udiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_pay   ({r4_zero, r4_sgn, r4_pay}),
        .o_valid (d_v),
        .o_q     (d_q),
        .o_den   (d_den),
        .o_pay   (d_pay)
    );

    assign {d_zero, d_sgn, d_ext} = d_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (d_zero) begin
                    o_u[i] <= '0;
                end else if (d_sgn[i]) begin
                    o_u[i] <= -$signed({1'b0, d_q[i]});
                end else begin
                    o_u[i] <= $signed({1'b0, d_q[i]});
                end
            end
            o_len <= d_zero ? '0 : d_den[LW-1:0];
            o_pay <= d_ext;
        end
    end

endmodule

### rtl/core/lqb_out.sv
module lqb_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lqb_pkg::t_packet i_pkt,
    output logic             o_take,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_shown,
    output logic [1:0]       o_column,
    output logic [31:0]      o_vec_x,
    output logic [31:0]      o_vec_y,
    output logic [31:0]      o_vec_z,
    output logic             o_last
);

    logic             r_busy;
    logic [1:0]       r_idx;
    lqb_pkg::t_packet r_pkt;
    logic             last_word;

    assign last_word = !r_pkt.shown || (r_idx == lqb_pkg::COL_ORIGIN);
    // free when empty or when the final word of a line leaves now
    assign o_take    = !r_busy || (!i_stall && last_word);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= lqb_pkg::COL_WIDTH;
        end else if (o_take) begin
            r_busy <= i_valid;
            r_idx  <= lqb_pkg::COL_WIDTH;
        end else if (!i_stall) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_pkt <= i_pkt;
        end
    end

    assign o_valid  = r_busy;
    assign o_shown  = r_pkt.shown;
    assign o_column = r_pkt.shown ? r_idx : lqb_pkg::COL_WIDTH;
    assign o_vec_x  = r_pkt.shown ? r_pkt.vec[r_idx][0] : '0;
    assign o_vec_y  = r_pkt.shown ? r_pkt.vec[r_idx][1] : '0;
    assign o_vec_z  = r_pkt.shown ? r_pkt.vec[r_idx][2] : '0;
    assign o_last   = last_word;

endmodule

### bench/tb_line_quad_basis.sv
module tb_line_quad_basis;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC       = 16;
    localparam longint THIN_Q     = ((64'sd1 << FRAC) + 5000) / 10000;
    localparam longint NEAR_Y_Q   = ((64'sd99 << FRAC) + 50) / 100;
    localparam int     DRAIN_CYC  = 400;
    localparam int     HOLD_CYC   = 700;
    localparam longint CYC_LIMIT  = 1000000;
    localparam int     N_DIRECTED = 21;
    localparam int     N_RANDOM   = 111;

    typedef longint t_vec3 [3];

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [30:0]        w;
        bit                 hid;   // expected hidden word typed in
    } t_line;

    typedef struct {
        logic               shown;
        logic [1:0]         column;
        logic signed [31:0] x, y, z;
        logic               last;
    } t_col_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [31:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic [30:0]        i_line_width = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_shown;
    logic [1:0]         o_column;
    logic signed [31:0] o_vec_x, o_vec_y, o_vec_z;
    logic               o_last;

    t_col_word pending_cols[$];
    int        errors = 0;
    longint    cycles = 0;
    int        tx_idle_pct = 0;
    int        rx_idle_pct = 0;
    bit        hold_req = 1'b0;

    line_quad_basis #(.FRAC_BITS(FRAC)) i_dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYC_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    // unit vector and length, both with FRAC fraction bits
    function automatic void unit_vec(input t_vec3 v, output t_vec3 u, output longint len);
        longint unsigned m [3];
        longint unsigned mx, sum, l, den, q, t;
        int s;
        mx = 0;
        sum = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = mag(v[i]);
            if (m[i] > mx) mx = m[i];
        end
        while ((mx >> s) >= (64'd1 << 31)) s++;
        for (int i = 0; i < 3; i++) begin
            t = m[i] >> s;
            sum += t * t;
        end
        l = isqrt(sum);
        if (l == 0) begin
            u = '{0, 0, 0};
            len = 0;
            return;
        end
        den = l << s;
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << FRAC) + den / 2) / den;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        len = den;
    endfunction

    function automatic longint scale_q(input longint a, input longint b);
        longint p;
        longint unsigned r;
        p = a * b;
        r = (mag(p) + (64'd1 << (FRAC - 1))) >> FRAC;
        return p < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic t_col_word mk_word(input logic [1:0] c, input t_vec3 v, input logic lst);
        t_col_word w;
        w.shown = 1'b1;
        w.column = c;
        w.x = clamp32(v[0]);
        w.y = clamp32(v[1]);
        w.z = clamp32(v[2]);
        w.last = lst;
        return w;
    endfunction

    function automatic void predict_basis(input t_line ln);
        t_vec3 st, d, dir, xc, xa, zc, za, c;
        longint len, dummy;
        t_col_word hidden;
        st = '{longint'(ln.sx), longint'(ln.sy), longint'(ln.sz)};
        d  = '{longint'(ln.ex) - st[0], longint'(ln.ey) - st[1], longint'(ln.ez) - st[2]};
        unit_vec(d, dir, len);
        if (len < THIN_Q || len == 0) begin
            hidden = '{1'b0, lqb_pkg::COL_WIDTH, '0, '0, '0, 1'b1};
            pending_cols.push_back(hidden);
            return;
        end
        if (longint'(mag(dir[1])) < NEAR_Y_Q) xc = '{-dir[2], 0, dir[0]};
        else xc = '{0, dir[2], -dir[1]};
        unit_vec(xc, xa, dummy);
        zc[0] = scale_q(xa[1], dir[2]) - scale_q(xa[2], dir[1]);
        zc[1] = scale_q(xa[2], dir[0]) - scale_q(xa[0], dir[2]);
        zc[2] = scale_q(xa[0], dir[1]) - scale_q(xa[1], dir[0]);
        unit_vec(zc, za, dummy);
        for (int i = 0; i < 3; i++) c[i] = scale_q(xa[i], longint'(ln.w));
        pending_cols.push_back(mk_word(lqb_pkg::COL_WIDTH, c, 1'b0));
        for (int i = 0; i < 3; i++) c[i] = scale_q(dir[i], len);
        pending_cols.push_back(mk_word(lqb_pkg::COL_LENGTH, c, 1'b0));
        pending_cols.push_back(mk_word(lqb_pkg::COL_NORMAL, za, 1'b0));
        for (int i = 0; i < 3; i++) c[i] = st[i] + d[i] / 2;
        pending_cols.push_back(mk_word(lqb_pkg::COL_ORIGIN, c, 1'b1));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_line(input t_line ln);
        t_col_word hidden;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_x    <= ln.sx;
        i_start_y    <= ln.sy;
        i_start_z    <= ln.sz;
        i_end_x      <= ln.ex;
        i_end_y      <= ln.ey;
        i_end_z      <= ln.ez;
        i_line_width <= ln.w;
        do @(posedge i_clk); while (o_in_stall);
        if (ln.hid) begin
            hidden = '{1'b0, lqb_pkg::COL_WIDTH, '0, '0, '0, 1'b1};
            pending_cols.push_back(hidden);
        end else begin
            predict_basis(ln);
        end
        @(negedge i_clk);
    endtask

    function automatic t_line rand_line();
        t_line ln;
        int    kind;
        kind = $urandom_range(99);
        ln.hid = 1'b0;
        ln.w = 31'($urandom());
        ln.sx = $urandom(); ln.sy = $urandom(); ln.sz = $urandom();
        if (kind < 60) begin
            // typical scene coordinates
            ln.sx = $signed(ln.sx) >>> 8;
            ln.sy = $signed(ln.sy) >>> 8;
            ln.sz = $signed(ln.sz) >>> 8;
            ln.ex = ln.sx + ($signed(32'($urandom())) >>> 10);
            ln.ey = ln.sy + ($signed(32'($urandom())) >>> 10);
            ln.ez = ln.sz + ($signed(32'($urandom())) >>> 10);
            ln.w = ln.w >> $urandom_range(30, 8);
        end else if (kind < 72) begin
            // nearly vertical line
            ln.sx = $signed(ln.sx) >>> 8;
            ln.sy = $signed(ln.sy) >>> 8;
            ln.sz = $signed(ln.sz) >>> 8;
            ln.ex = ln.sx + $signed(32'($urandom_range(2000))) - 1000;
            ln.ey = ln.sy + ($urandom_range(1) ? 32'sd300000 : -32'sd300000);
            ln.ez = ln.sz + $signed(32'($urandom_range(2000))) - 1000;
        end else if (kind < 82) begin
            // short enough to fall below the hidden threshold
            ln.ex = ln.sx + $signed(32'($urandom_range(8))) - 4;
            ln.ey = ln.sy + $signed(32'($urandom_range(8))) - 4;
            ln.ez = ln.sz + $signed(32'($urandom_range(8))) - 4;
        end else begin
            ln.ex = $urandom(); ln.ey = $urandom(); ln.ez = $urandom();
        end
        return ln;
    endfunction

    t_line directed [N_DIRECTED] = '{
        //  sx            sy            sz        ex            ey            ez
        '{0, 0, 0, 0, 0, 0, 31'h0001_0000, 1'b1},                           // zero length
        '{32'sh0010_0000, 5, -7, 32'sh0010_0001, 5, -7, 31'h0001_0000, 1'b1}, // below threshold
        '{0, 0, 0, 4, 4, 4, 31'h1, 1'b1},                                   // root 6, hidden
        '{0, 0, 0, 7, 0, 0, 31'h0001_0000, 1'b0},                           // exactly threshold
        '{0, 0, 0, 32'sh0001_0000, 0, 0, 31'h0001_0000, 1'b0},              // along x
        '{0, 0, 0, 0, 32'sh0003_0000, 0, 31'h0002_0000, 1'b0},              // along +y
        '{0, 32'sh0003_0000, 0, 0, 0, 0, 31'h0002_0000, 1'b0},              // along -y
        '{0, 0, 0, 0, 0, 32'sh0005_8000, 31'h0000_8000, 1'b0},              // along z
        '{0, 0, 0, 32'sh0000_2000, 32'sh0001_0000, 0, 31'h0001_0000, 1'b0}, // y near 0.99
        '{0, 0, 0, 32'sh0000_1c00, 32'sh0001_0000, 0, 31'h0001_0000, 1'b0},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff, 1'b0},
        '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h0, 1'b0},
        '{32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 0, 31'h7fff_ffff, 1'b0},
        '{0, 32'sh8000_0000, 0, 0, 32'sh7fff_ffff, 0, 31'h7fff_ffff, 1'b0},
        '{32'sh7fff_ffff, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 32'sh7fff_ffff,
          31'h4000_0000, 1'b0},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff, 1'b1},
        '{-5, -5, -5, 5, 5, 5, 31'h7fff_ffff, 1'b0},                        // midpoint at the origin
        '{3, -3, 9, -4, 4, -10, 31'h0001_0000, 1'b0},
        '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
          -32'sh0004_0000, 32'sh0005_0000, -32'sh0006_0000, 31'h0003_8000, 1'b0},
        '{0, 0, 0, -32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, 31'h7fff_ffff, 1'b0},
        '{32'sh5555_5555, -32'sh2aaa_aaaa, 32'sh1234_5678,
          -32'sh5555_5555, 32'sh2aaa_aaaa, -32'sh1234_5678, 31'h5555_5555, 1'b0}
    };

    // receiver back-pressure, with one long hold-off on request
    always @(negedge i_clk) begin
        static int  hold_left = 0;
        static bit  hold_done = 1'b0;
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYC;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_col_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_cols.size() == 0) begin
                $display("%0t: unexpected word shown=%0d column=%0d vec=(%0d,%0d,%0d) last=%0d",
                         $realtime, o_shown, o_column, o_vec_x, o_vec_y, o_vec_z, o_last);
                errors++;
            end else begin
                want = pending_cols.pop_front();
                if (o_shown !== want.shown || o_column !== want.column || o_vec_x !== want.x
                        || o_vec_y !== want.y || o_vec_z !== want.z || o_last !== want.last) begin
                    $display("%0t: mismatch expected shown=%0d column=%0d vec=(%0d,%0d,%0d) last=%0d",
                             $realtime, want.shown, want.column, want.x, want.y, want.z,
                             want.last);
                    $display("%0t:          actual   shown=%0d column=%0d vec=(%0d,%0d,%0d) last=%0d",
                             $realtime, o_shown, o_column, o_vec_x, o_vec_y, o_vec_z, o_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) send_line(directed[i]);

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 77 : 0;
            rx_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 17 : 0;
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < N_RANDOM / 3; n++) begin
                if (ph == 1 && n == 20) begin
                    // let everything drain before going on
                    i_in_valid <= 1'b0;
                    while (pending_cols.size() != 0) @(negedge i_clk);
                end
                send_line(rand_line());
            end
        end
        i_in_valid <= 1'b0;

        while (pending_cols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/lqb_pkg.sv
rtl/core/lqb_isqrt.sv
rtl/core/lqb_udiv.sv
rtl/core/lqb_norm.sv
rtl/core/lqb_out.sv
rtl/core/line_quad_basis.sv
bench/tb_line_quad_basis.sv
